/* design/mad_pkg.sv */
// Shared types, constants and the divide-by-window helper for the moving
// average detrend block. No dependencies; used by every design file.
package mad_pkg;

    // Fixed configuration of the filter.
    localparam int SAMPLE_BITS = 16;
    localparam int HALF_WINDOW = 3;
    localparam int WINDOW_LEN  = 2 * HALF_WINDOW + 1;
    localparam int OUT_BITS    = SAMPLE_BITS + 1;

    // A window sum needs room for WINDOW_LEN full-scale samples.
    localparam int SUM_BITS    = SAMPLE_BITS + $clog2(WINDOW_LEN);
    localparam int MAG_BITS    = SUM_BITS - 1;

    // Fill count saturates at HALF_WINDOW + 1; flush counter runs HALF_WINDOW..0.
    localparam int FILL_BITS   = $clog2(HALF_WINDOW + 2);
    localparam int FLUSH_BITS  = $clog2(HALF_WINDOW + 1);

    // Reciprocal of the window length, rounded up, for an exact floor divide
    // of any magnitude below 2**MAG_BITS.
    localparam int RECIP_SHIFT = MAG_BITS + 3;
    localparam longint RECIP   = ((64'd1 << RECIP_SHIFT) + WINDOW_LEN - 1) / WINDOW_LEN;
    localparam int PROD_BITS   = MAG_BITS + RECIP_SHIFT;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic signed [SUM_BITS-1:0]    t_sum;
    typedef logic signed [OUT_BITS-1:0]    t_value;

    // One pending result: the centre sample and the window sum around it.
    typedef struct packed {
        logic    valid;
        logic    last;
        t_sample center;
        t_sum    sum;
    } t_pend;

    // Window sum divided by the window length, rounded toward zero.
    function automatic t_value div_trunc(input t_sum sum);
        logic [MAG_BITS-1:0]    mag;
        logic [PROD_BITS-1:0]   prod;
        logic [SAMPLE_BITS-1:0] quo;
        t_value                 res;
        begin
            mag  = sum[SUM_BITS-1] ? MAG_BITS'(-sum) : MAG_BITS'(sum);
            prod = PROD_BITS'(mag) * PROD_BITS'(RECIP);
            quo  = prod[RECIP_SHIFT +: SAMPLE_BITS];
            res  = t_value'({1'b0, quo});
            if (sum[SUM_BITS-1]) begin
                res = -res;
            end
            return res;
        end
    endfunction

endpackage

/* design/mad_out_stage.sv */
// Result stage of the moving average detrend block: divides the window sum,
// subtracts it from the centre sample and holds the result beat. Uses mad_pkg.
module mad_out_stage import mad_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_pend  i_pend,
    output logic   o_take,
    output logic   o_out_valid,
    input  logic   i_out_ready,
    output t_value o_value,
    output logic   o_last
);

    logic   r_valid;
    t_value r_value;
    logic   r_last;
    t_value w_quo;
    t_value w_center;

    // Load a pending result whenever the register is empty or being drained.
    assign o_take   = i_pend.valid && (!r_valid || i_out_ready);

    // Centre sample minus the truncated window mean; the true result fits.
    assign w_quo    = div_trunc(i_pend.sum);
    assign w_center = t_value'(i_pend.center);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_value <= w_center - w_quo;
            r_last  <= i_pend.last;
        end
    end

    assign o_out_valid = r_valid;
    assign o_value     = r_value;
    assign o_last      = r_last;

endmodule

/* design/moving_average_detrend.sv */
// Moving average detrend: each output beat is a sample minus the sum of the
// seven samples centred on it (clipped to the frame) divided by seven, rounded
// toward zero. Outside a flush, one sample beat is taken per clock while
// results drain. Output for a position is held in the pending slot once three
// later samples have arrived, then passes through the result register. A beat
// with frame_end set is followed by a flush in which no input is taken: the
// window line shifts in zeros to flush the remaining positions, giving one to
// four results for that beat, the last one flagged. The window line and fill
// count return to zero after the flush. Uses mad_pkg and mad_out_stage.
module moving_average_detrend import mad_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_sample i_sample,
    input  logic    i_frame_end,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_value  o_value,
    output logic    o_last
);

    t_sample                r_window [WINDOW_LEN];
    t_sample                n_window [WINDOW_LEN];
    t_sample                p_window [WINDOW_LEN];
    t_sum                   r_sum;
    t_sum                   n_sum;
    t_sum                   p_sum;
    logic [FILL_BITS-1:0]   r_fill;
    logic [FILL_BITS-1:0]   n_fill;
    logic [FILL_BITS-1:0]   w_fill_inc;
    logic [FLUSH_BITS-1:0]  r_flush;
    logic [FLUSH_BITS-1:0]  n_flush;
    t_pend                  r_pend;
    t_pend                  n_pend;
    t_sample                w_push_val;
    logic                   w_take;
    logic                   w_step_ok;
    logic                   w_accept;
    logic                   w_flush_step;

    // The pending slot can advance when empty or when the result stage takes it.
    assign w_step_ok    = !r_pend.valid || w_take;
    assign o_in_ready   = (r_flush == '0) && w_step_ok;
    assign w_accept     = i_in_valid && o_in_ready;
    assign w_flush_step = (r_flush != '0) && w_step_ok;
    assign w_push_val   = w_accept ? i_sample : '0;

    // Window line after one shift, with the running sum kept alongside.
    always_comb begin
        p_window[0] = w_push_val;
        for (int i = 1; i < WINDOW_LEN; i++) begin
            p_window[i] = r_window[i-1];
        end
        p_sum = r_sum - t_sum'(r_window[WINDOW_LEN-1]) + t_sum'(w_push_val);
    end

    assign w_fill_inc = (r_fill == FILL_BITS'(HALF_WINDOW + 1)) ? r_fill
                                                                : r_fill + 1'b1;

    // Next state for sample beats and flush steps.
    always_comb begin
        n_window = r_window;
        n_sum    = r_sum;
        n_fill   = r_fill;
        n_flush  = r_flush;
        n_pend   = r_pend;
        if (w_take) begin
            n_pend.valid = 1'b0;
        end
        if (w_accept) begin
            n_window      = p_window;
            n_sum         = p_sum;
            n_fill        = w_fill_inc;
            n_pend.valid  = (w_fill_inc > FILL_BITS'(HALF_WINDOW));
            n_pend.last   = 1'b0;
            n_pend.center = p_window[HALF_WINDOW];
            n_pend.sum    = p_sum;
            if (i_frame_end) begin
                n_flush = FLUSH_BITS'(HALF_WINDOW);
            end
        end else if (w_flush_step) begin
            // A flush step covers a position inside the frame only when enough
            // samples of the frame were seen.
            n_window      = p_window;
            n_sum         = p_sum;
            n_pend.valid  = (r_fill >= FILL_BITS'(r_flush));
            n_pend.last   = (r_flush == FLUSH_BITS'(1));
            n_pend.center = p_window[HALF_WINDOW];
            n_pend.sum    = p_sum;
            n_flush       = r_flush - 1'b1;
            if (r_flush == FLUSH_BITS'(1)) begin
                n_window = '{default: '0};
                n_sum    = '0;
                n_fill   = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= '{default: '0};
            r_sum    <= '0;
            r_fill   <= '0;
            r_flush  <= '0;
            r_pend   <= '0;
        end else begin
            r_window <= n_window;
            r_sum    <= n_sum;
            r_fill   <= n_fill;
            r_flush  <= n_flush;
            r_pend   <= n_pend;
        end
    end

    // Divide, subtract and hold the result beat.
    mad_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pend      (r_pend),
        .o_take      (w_take),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_value     (o_value),
        .o_last      (o_last)
    );

endmodule

/* design/mad_checker.sv */
// Port-level checks for the moving average detrend block, attached by bind.
// Uses mad_pkg for the port types.
module mad_checker import mad_pkg::*; (
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    i_in_valid,
    input logic    o_in_ready,
    input t_sample i_sample,
    input logic    i_frame_end,
    input logic    o_out_valid,
    input logic    i_out_ready,
    input t_value  o_value,
    input logic    o_last
);

    // A sample beat that is not taken stays offered unchanged.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_sample) && $stable(i_frame_end))
        else $error("sample beat changed while waiting");

    // A result beat that is not taken stays offered unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_value) && $stable(o_last))
        else $error("result beat changed while stalled");

    // The flush after a frame-end beat blocks the input channel.
    a_flush_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_frame_end |=> !o_in_ready)
        else $error("input taken during frame-end flush");

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind moving_average_detrend mad_checker u_mad_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_sample    (i_sample),
    .i_frame_end (i_frame_end),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_value     (o_value),
    .o_last      (o_last)
);
